FILE: rtl/core/sswq_pkg.sv
// sswq_pkg: shared constants, codes and controller/datapath structs
// for the service slot wait queue. No dependencies.
package sswq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int ID_BITS     = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int LIMIT_W     = 4;
	localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int SESS_W      = 32;
	localparam int FUNC_W      = 3;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 3'd0,
		FN_REMOVE = 3'd1,
		FN_FINISH = 3'd2,
		FN_ON     = 3'd3,
		FN_OFF    = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START_NEW,
		OP_APPEND,
		OP_DELETE,
		OP_PROMOTE,
		OP_POWER_ON,
		OP_POWER_OFF
	} op_t;

	typedef struct packed {
		logic capture;
		logic search;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              found;
		logic              cur_match;
		logic              slot_busy;
		logic              q_empty;
		logic              q_room;
	} status_t;

endpackage

FILE: rtl/core/service_slot_wait_queue.sv
// service_slot_wait_queue: top level, one service slot with a bounded
// wait list keyed by client id. Depends on sswq_pkg, sswq_ctrl, sswq_dp.
//
// A command word (func, client_id) is taken at a rising edge with start high
// and busy low. busy stays high while the word is worked on. The result word
// shows on the result ports for exactly one cycle with done high; the
// receiver cannot stall, so nothing is held back. slot_busy, served_client,
// queued_count, powered and sessions_total give the state after the command.
// Each word passes capture, parallel compare of all queue cells and apply;
// a new command may be taken in the cycle that done is high. These steps are
// the controller's three states; deletion shifts all cells at once.
// wait_limit is to be written through wr_en/wr_data only while the block is
// idle; the block itself leaves this to the user. Values above the queue
// depth act as the depth.
// Reset: slot idle, queue empty, powered on, session count zero, limit four.
// Queue cells have no reset; only cells below the fill count are ever read.
module service_slot_wait_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [sswq_pkg::FUNC_W-1:0]         func,
	input  logic [sswq_pkg::ID_BITS-1:0]        client_id,
	input  logic                                wr_en,
	input  logic [sswq_pkg::LIMIT_W-1:0]        wr_data,
	output logic                                done,
	output logic                                accepted,
	output logic                                session_started,
	output logic                                slot_busy,
	output logic [sswq_pkg::ID_BITS-1:0]        served_client,
	output logic [sswq_pkg::CNT_W-1:0]          queued_count,
	output logic                                powered,
	output logic [sswq_pkg::SESS_W-1:0]         sessions_total
);

	sswq_pkg::cmd_t    cmd;
	sswq_pkg::status_t status;

	sswq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.done            (done),
		.accepted        (accepted),
		.session_started (session_started),
		.status          (status),
		.cmd             (cmd)
	);

	sswq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.func           (func),
		.client_id      (client_id),
		.wr_en          (wr_en),
		.wr_data        (wr_data),
		.slot_busy      (slot_busy),
		.served_client  (served_client),
		.queued_count   (queued_count),
		.powered        (powered),
		.sessions_total (sessions_total)
	);

endmodule

FILE: rtl/core/sswq_dp.sv
// sswq_dp: datapath of the service slot wait queue: slot, wait list cells,
// counters and the limit register. Depends on sswq_pkg.
module sswq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sswq_pkg::cmd_t                      cmd,
	output sswq_pkg::status_t                   status,
	input  logic [sswq_pkg::FUNC_W-1:0]         func,
	input  logic [sswq_pkg::ID_BITS-1:0]        client_id,
	input  logic                                wr_en,
	input  logic [sswq_pkg::LIMIT_W-1:0]        wr_data,
	output logic                                slot_busy,
	output logic [sswq_pkg::ID_BITS-1:0]        served_client,
	output logic [sswq_pkg::CNT_W-1:0]          queued_count,
	output logic                                powered,
	output logic [sswq_pkg::SESS_W-1:0]         sessions_total
);

	logic [sswq_pkg::FUNC_W-1:0]  func_q;
	logic [sswq_pkg::ID_BITS-1:0] id_q;
	logic [sswq_pkg::ID_BITS-1:0] cur_q;
	logic                         busy_q;
	logic [sswq_pkg::CNT_W-1:0]   fill_q;
	logic                         power_q;
	logic [sswq_pkg::SESS_W-1:0]  sess_q;
	logic [sswq_pkg::LIMIT_W-1:0] limit_q;
	logic [sswq_pkg::ID_BITS-1:0] queue_q [sswq_pkg::QUEUE_DEPTH];
	logic [sswq_pkg::QUEUE_DEPTH-1:0] match_q;
	logic [sswq_pkg::QUEUE_DEPTH-1:0] match;
	logic [sswq_pkg::QUEUE_DEPTH-1:0] from_pos;
	logic [sswq_pkg::QUEUE_DEPTH-1:0] shift_sel;
	logic                         shift_en;

	// parallel compare lanes, one per queue cell
	always_comb begin
		for (int i = 0; i < sswq_pkg::QUEUE_DEPTH; i++) begin
			match[i] = (sswq_pkg::CNT_W'(i) < fill_q) && (queue_q[i] == id_q);
		end
	end

	// cells at and above the first match take their upper neighbor
	always_comb begin
		from_pos[0] = match_q[0];
		for (int i = 1; i < sswq_pkg::QUEUE_DEPTH; i++) begin
			from_pos[i] = from_pos[i-1] | match_q[i];
		end
	end

	always_comb begin
		shift_en  = (cmd.op == sswq_pkg::OP_DELETE) || (cmd.op == sswq_pkg::OP_PROMOTE);
		shift_sel = (cmd.op == sswq_pkg::OP_PROMOTE) ? '1 : from_pos;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			id_q   <= client_id;
		end
		if (cmd.search) begin
			match_q <= match;
		end
		for (int i = 0; i < sswq_pkg::QUEUE_DEPTH - 1; i++) begin
			if (shift_en && shift_sel[i]) begin
				queue_q[i] <= queue_q[i+1];
			end
		end
		if (cmd.op == sswq_pkg::OP_APPEND) begin
			queue_q[fill_q[sswq_pkg::IDX_W-1:0]] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			busy_q  <= 1'b0;
			fill_q  <= '0;
			power_q <= 1'b1;
			sess_q  <= '0;
			limit_q <= sswq_pkg::LIMIT_RESET;
		end else begin
			if (wr_en) begin
				limit_q <= wr_data;
			end
			case (cmd.op)
				sswq_pkg::OP_START_NEW: begin
					cur_q  <= id_q;
					busy_q <= 1'b1;
					sess_q <= sess_q + 1'b1;
				end
				sswq_pkg::OP_APPEND: begin
					fill_q <= fill_q + 1'b1;
				end
				sswq_pkg::OP_DELETE: begin
					fill_q <= fill_q - 1'b1;
				end
				sswq_pkg::OP_PROMOTE: begin
					if (fill_q == '0) begin
						cur_q  <= '0;
						busy_q <= 1'b0;
					end else begin
						cur_q  <= queue_q[0];
						busy_q <= 1'b1;
						fill_q <= fill_q - 1'b1;
						sess_q <= sess_q + 1'b1;
					end
				end
				sswq_pkg::OP_POWER_ON:  power_q <= 1'b1;
				sswq_pkg::OP_POWER_OFF: power_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_comb begin
		status.func      = func_q;
		status.found     = |match_q;
		status.cur_match = (cur_q == id_q);
		status.slot_busy = busy_q;
		status.q_empty   = (fill_q == '0);
		// a limit above the depth acts as the depth
		status.q_room    = (sswq_pkg::CMP_W'(fill_q) < sswq_pkg::CMP_W'(limit_q))
			&& (sswq_pkg::CMP_W'(fill_q) < sswq_pkg::CMP_W'(sswq_pkg::QUEUE_DEPTH));
	end

	assign slot_busy      = busy_q;
	assign served_client  = busy_q ? cur_q : '0;
	assign queued_count   = fill_q;
	assign powered        = power_q;
	assign sessions_total = sess_q;

endmodule

FILE: rtl/core/sswq_ctrl.sv
// sswq_ctrl: controller state machine of the service slot wait queue;
// picks the datapath operation and raises the result strobe. Depends on sswq_pkg.
module sswq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output logic              accepted,
	output logic              session_started,
	input  sswq_pkg::status_t status,
	output sswq_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   ok_q;
	logic   started_q;
	logic   ok;
	logic   started;
	sswq_pkg::op_t op;

	// decision on the captured word and the searched queue
	always_comb begin
		op      = sswq_pkg::OP_NONE;
		ok      = 1'b0;
		started = 1'b0;
		case (status.func)
			sswq_pkg::FN_ADD: begin
				if (!status.slot_busy) begin
					op      = sswq_pkg::OP_START_NEW;
					ok      = 1'b1;
					started = 1'b1;
				end else if (status.q_room) begin
					op = sswq_pkg::OP_APPEND;
					ok = 1'b1;
				end
			end
			sswq_pkg::FN_REMOVE: begin
				// queue is checked before the slot
				if (status.found) begin
					op = sswq_pkg::OP_DELETE;
					ok = 1'b1;
				end else if (status.slot_busy && status.cur_match) begin
					op      = sswq_pkg::OP_PROMOTE;
					ok      = 1'b1;
					started = !status.q_empty;
				end
			end
			sswq_pkg::FN_FINISH: begin
				if (status.slot_busy) begin
					op      = sswq_pkg::OP_PROMOTE;
					ok      = 1'b1;
					started = !status.q_empty;
				end
			end
			sswq_pkg::FN_ON: begin
				op = sswq_pkg::OP_POWER_ON;
				ok = 1'b1;
			end
			sswq_pkg::FN_OFF: begin
				if (!status.slot_busy && status.q_empty) begin
					op = sswq_pkg::OP_POWER_OFF;
					ok = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.search  = (state_q == ST_LOOK);
		cmd.op      = (state_q == ST_APPLY) ? op : sswq_pkg::OP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			ok_q      <= 1'b0;
			started_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q   <= ST_IDLE;
					done_q    <= 1'b1;
					ok_q      <= ok;
					started_q <= started;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign accepted        = ok_q;
	assign session_started = started_q;

endmodule

FILE: rtl/core/sswq_chk.sv
// sswq_chk: port-level checks for service_slot_wait_queue, bound to the top.
// Depends on sswq_pkg.
module sswq_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic                                accepted,
	input logic                                session_started,
	input logic                                slot_busy,
	input logic [sswq_pkg::ID_BITS-1:0]        served_client,
	input logic [sswq_pkg::CNT_W-1:0]          queued_count,
	input logic                                powered,
	input logic [sswq_pkg::SESS_W-1:0]         sessions_total
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !slot_busy |-> served_client == '0)
		else $error("idle slot shows a client id");

	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && session_started |-> accepted && slot_busy)
		else $error("session start without accepted busy slot");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> queued_count <= sswq_pkg::CNT_W'(sswq_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a word in work");

endmodule

bind service_slot_wait_queue sswq_chk u_chk (.*);

FILE: tb/tb_service_slot_wait_queue.sv
// tb_service_slot_wait_queue: self-checking bench for the service slot wait queue.
// Drives a directed table and then random command words, and checks every result
// word against a typed-in or predicted word. Depends on sswq_pkg and service_slot_wait_queue.
module tb_service_slot_wait_queue;

	localparam int CYCLE_LIMIT = 40000;
	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 38;
	localparam int QUIET_FIRST = 150;
	localparam int QUIET_LAST = 300;
	localparam logic [sswq_pkg::FUNC_W-1:0] FN_SPARE_LO =
		sswq_pkg::FUNC_W'(sswq_pkg::FN_OFF + 1);
	localparam logic [sswq_pkg::FUNC_W-1:0] FN_SPARE_MID =
		sswq_pkg::FUNC_W'(sswq_pkg::FN_OFF + 2);
	localparam logic [sswq_pkg::FUNC_W-1:0] FN_SPARE_HI = '1;
	localparam logic [sswq_pkg::LIMIT_W-1:0] PHASE_LIMITS [PHASES] =
		'{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd12, 4'd2, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8};

	typedef struct packed {
		logic                         accepted;
		logic                         started;
		logic                         busy;
		logic [sswq_pkg::ID_BITS-1:0] client;
		logic [sswq_pkg::CNT_W-1:0]   count;
		logic                         powered;
		logic [sswq_pkg::SESS_W-1:0]  sessions;
	} slot_report_t;

	typedef struct {
		logic [sswq_pkg::FUNC_W-1:0]  fn;
		logic [sswq_pkg::ID_BITS-1:0] id;
		bit                           known;
		slot_report_t                 want;
	} plan_row_t;

	localparam slot_report_t NO_WANT = '0;

	// rows marked known carry the result word typed in; the rest use the prediction
	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		'{sswq_pkg::FN_FINISH, 16'hFFFF, 1'b1,
			'{1'b0, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b1, 32'd0}},
		'{sswq_pkg::FN_REMOVE, 16'h0005, 1'b1,
			'{1'b0, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b1, 32'd0}},
		'{sswq_pkg::FN_OFF, 16'h0001, 1'b1,
			'{1'b1, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 32'd0}},
		'{sswq_pkg::FN_ADD, 16'hFFFF, 1'b1,
			'{1'b1, 1'b1, 1'b1, 16'hFFFF, 4'd0, 1'b0, 32'd1}},
		'{sswq_pkg::FN_OFF, 16'h0001, 1'b1,
			'{1'b0, 1'b0, 1'b1, 16'hFFFF, 4'd0, 1'b0, 32'd1}},
		'{sswq_pkg::FN_ON, 16'h0000, 1'b1,
			'{1'b1, 1'b0, 1'b1, 16'hFFFF, 4'd0, 1'b1, 32'd1}},
		'{sswq_pkg::FN_ADD, 16'h0001, 1'b1,
			'{1'b1, 1'b0, 1'b1, 16'hFFFF, 4'd1, 1'b1, 32'd1}},
		'{sswq_pkg::FN_ADD,    16'h0001, 1'b0, NO_WANT},
		'{sswq_pkg::FN_ADD,    16'h8000, 1'b0, NO_WANT},
		'{sswq_pkg::FN_ADD,    16'hFFFF, 1'b0, NO_WANT},
		'{sswq_pkg::FN_ADD, 16'hAAAA, 1'b1,
			'{1'b0, 1'b0, 1'b1, 16'hFFFF, 4'd4, 1'b1, 32'd1}},
		'{sswq_pkg::FN_REMOVE, 16'hFFFF, 1'b0, NO_WANT},
		'{sswq_pkg::FN_REMOVE, 16'h0001, 1'b0, NO_WANT},
		'{sswq_pkg::FN_REMOVE, 16'hFFFF, 1'b0, NO_WANT},
		'{sswq_pkg::FN_REMOVE, 16'h1234, 1'b0, NO_WANT},
		'{FN_SPARE_LO,         16'h0001, 1'b0, NO_WANT},
		'{FN_SPARE_MID,        16'h8000, 1'b0, NO_WANT},
		'{FN_SPARE_HI,         16'h5555, 1'b0, NO_WANT},
		'{sswq_pkg::FN_FINISH, 16'h0000, 1'b0, NO_WANT},
		'{sswq_pkg::FN_OFF,    16'h0000, 1'b0, NO_WANT},
		'{sswq_pkg::FN_REMOVE, 16'h8000, 1'b0, NO_WANT},
		'{sswq_pkg::FN_FINISH, 16'h0000, 1'b1,
			'{1'b0, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b1, 32'd3}},
		'{sswq_pkg::FN_ADD,    16'h7FFF, 1'b0, NO_WANT},
		'{sswq_pkg::FN_FINISH, 16'h2AAA, 1'b0, NO_WANT}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [sswq_pkg::FUNC_W-1:0]   func = '0;
	logic [sswq_pkg::ID_BITS-1:0]  client_id = '0;
	logic                          wr_en = 1'b0;
	logic [sswq_pkg::LIMIT_W-1:0]  wr_data = '0;
	logic                          done;
	logic                          accepted;
	logic                          session_started;
	logic                          slot_busy;
	logic [sswq_pkg::ID_BITS-1:0]  served_client;
	logic [sswq_pkg::CNT_W-1:0]    queued_count;
	logic                          powered;
	logic [sswq_pkg::SESS_W-1:0]   sessions_total;

	// predicted slot state
	logic                          slot_taken;
	logic [sswq_pkg::ID_BITS-1:0]  slot_id;
	logic [sswq_pkg::ID_BITS-1:0]  waiting [$];
	logic                          power_on;
	logic [sswq_pkg::SESS_W-1:0]   session_count;
	logic [sswq_pkg::LIMIT_W-1:0]  wait_cap;

	slot_report_t        expected_words [$];
	slot_report_t        oldest;
	int                  mismatches = 0;
	int                  cycles = 0;
	int                  words_sent = 0;

	service_slot_wait_queue dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.client_id       (client_id),
		.wr_en           (wr_en),
		.wr_data         (wr_data),
		.done            (done),
		.accepted        (accepted),
		.session_started (session_started),
		.slot_busy       (slot_busy),
		.served_client   (served_client),
		.queued_count    (queued_count),
		.powered         (powered),
		.sessions_total  (sessions_total)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic promote_head();
		if (waiting.size() == 0) begin
			slot_taken = 1'b0;
			slot_id = '0;
			return 1'b0;
		end
		slot_id = waiting.pop_front();
		slot_taken = 1'b1;
		session_count = session_count + 1;
		return 1'b1;
	endfunction

	function automatic slot_report_t step_slot(input logic [sswq_pkg::FUNC_W-1:0] fn,
			input logic [sswq_pkg::ID_BITS-1:0] id);
		slot_report_t r;
		int cap;
		int hit;
		r = '0;
		hit = -1;
		cap = (wait_cap > sswq_pkg::QUEUE_DEPTH) ? sswq_pkg::QUEUE_DEPTH : int'(wait_cap);
		case (fn)
			sswq_pkg::FN_ADD: begin
				if (!slot_taken) begin
					slot_taken = 1'b1;
					slot_id = id;
					session_count = session_count + 1;
					r.accepted = 1'b1;
					r.started = 1'b1;
				end else if (waiting.size() < cap) begin
					waiting.insert(waiting.size(), id);
					r.accepted = 1'b1;
				end
			end
			sswq_pkg::FN_REMOVE: begin
				// queued copies win over the one in service
				foreach (waiting[i])
					if (hit < 0 && waiting[i] == id)
						hit = i;
				if (hit >= 0) begin
					waiting.delete(hit);
					r.accepted = 1'b1;
				end else if (slot_taken && slot_id == id) begin
					r.started = promote_head();
					r.accepted = 1'b1;
				end
			end
			sswq_pkg::FN_FINISH: begin
				if (slot_taken) begin
					r.started = promote_head();
					r.accepted = 1'b1;
				end
			end
			sswq_pkg::FN_ON: begin
				power_on = 1'b1;
				r.accepted = 1'b1;
			end
			sswq_pkg::FN_OFF: begin
				if (!slot_taken && waiting.size() == 0) begin
					power_on = 1'b0;
					r.accepted = 1'b1;
				end
			end
			default: ;
		endcase
		r.busy = slot_taken;
		r.client = slot_taken ? slot_id : '0;
		r.count = sswq_pkg::CNT_W'(waiting.size());
		r.powered = power_on;
		r.sessions = session_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: result word with none expected, expected none, actual %0h",
					$time, {accepted, session_started, slot_busy, served_client,
					queued_count, powered, sessions_total});
				mismatches++;
			end else begin
				oldest = expected_words.pop_front();
				check_field("accepted", 32'(oldest.accepted), 32'(accepted));
				check_field("session_started", 32'(oldest.started),
					32'(session_started));
				check_field("slot_busy", 32'(oldest.busy), 32'(slot_busy));
				check_field("served_client", 32'(oldest.client), 32'(served_client));
				check_field("queued_count", 32'(oldest.count), 32'(queued_count));
				check_field("powered", 32'(oldest.powered), 32'(powered));
				check_field("sessions_total", oldest.sessions, sessions_total);
			end
		end
	end

	// start stays high across back-to-back words; the word goes in once busy is low
	task automatic send_word(input logic [sswq_pkg::FUNC_W-1:0] fn,
			input logic [sswq_pkg::ID_BITS-1:0] id, input bit known,
			input slot_report_t want);
		slot_report_t predicted;
		start <= 1'b1;
		func <= fn;
		client_id <= id;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = step_slot(fn, id);
		expected_words.insert(expected_words.size(), known ? want : predicted);
		words_sent++;
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if ((words_sent < QUIET_FIRST || words_sent >= QUIET_LAST) &&
				$urandom_range(0, 99) < 6)
			pause_sender($urandom_range(1, 5));
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_wait_limit(input logic [sswq_pkg::LIMIT_W-1:0] v);
		wait_all_results();
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		wait_cap = v;
	endtask

	initial begin : stimulus
		logic [sswq_pkg::ID_BITS-1:0] id_pool [6];
		logic [sswq_pkg::FUNC_W-1:0]  fn;
		logic [sswq_pkg::ID_BITS-1:0] id;
		int                           roll;
		int                           n;
		int                           k;

		slot_taken = 1'b0;
		slot_id = '0;
		waiting.delete();
		power_on = 1'b1;
		session_count = '0;
		wait_cap = sswq_pkg::LIMIT_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r]) begin
			send_word(directed_plan[r].fn, directed_plan[r].id, directed_plan[r].known,
				directed_plan[r].want);
			maybe_idle();
		end

		// each phase starts from an idle block, so the sender also waits out all results here
		for (int p = 0; p < PHASES; p++) begin
			set_wait_limit(PHASE_LIMITS[p]);
			foreach (id_pool[j])
				id_pool[j] = sswq_pkg::ID_BITS'($urandom_range(1, 65535));
			for (int w = 0; w < WORDS_PER_PHASE; w++) begin
				roll = $urandom_range(0, 99);
				id = sswq_pkg::ID_BITS'($urandom_range(1, 65535));
				if (roll < 45) begin
					fn = sswq_pkg::FN_ADD;
					if ($urandom_range(0, 3) != 0)
						id = id_pool[$urandom_range(0, 5)];
				end else if (roll < 70) begin
					fn = sswq_pkg::FN_REMOVE;
					n = waiting.size() + (slot_taken ? 1 : 0);
					if (n > 0 && $urandom_range(0, 9) < 7) begin
						k = $urandom_range(0, n - 1);
						id = (k < waiting.size()) ? waiting[k] : slot_id;
					end else if ($urandom_range(0, 1) != 0) begin
						id = id_pool[$urandom_range(0, 5)];
					end
				end else if (roll < 87) begin
					fn = sswq_pkg::FN_FINISH;
				end else if (roll < 91) begin
					fn = sswq_pkg::FN_ON;
				end else if (roll < 95) begin
					fn = sswq_pkg::FN_OFF;
				end else begin
					fn = sswq_pkg::FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
				end
				send_word(fn, id, 1'b0, NO_WANT);
				maybe_idle();
			end
		end

		wait_all_results();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sswq_pkg.sv
rtl/core/sswq_dp.sv
rtl/core/sswq_ctrl.sv
rtl/core/service_slot_wait_queue.sv
rtl/core/sswq_chk.sv
tb/tb_service_slot_wait_queue.sv
